/* hdl/tx_frame_time_scheduler_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frame time scheduler
// Clocked, reset-qualified property wrappers.
// ----------------------------------------------------------------------------
`ifndef TX_FRAME_TIME_SCHEDULER_CORE_MACROS_SVH
`define TX_FRAME_TIME_SCHEDULER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define TFTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define TFTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tfts_pkg.sv */
// ----------------------------------------------------------------------------
// tfts_pkg
// Shared types and constants of the frame time scheduler.
// ----------------------------------------------------------------------------
package tfts_pkg;

    localparam int unsigned DIV_W  = 64;
    localparam int unsigned DVS_W  = 32;
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 33;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_PPS       = 3'd0;
    localparam logic [CFG_AW-1:0] REG_FRAME_INT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SAMPLE_P  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_OFFSET    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_START_S   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_AUTOSTART = 3'd5;

    // request codes
    localparam logic [1:0] REQ_TIMING = 2'd0;
    localparam logic [1:0] REQ_ENABLE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // reset values
    localparam logic [7:0]  PPS_RST       = 8'd100;
    localparam logic [31:0] FRAME_INT_RST = 32'd100000;
    localparam logic [31:0] SAMPLE_P_RST  = 32'd429;
    localparam logic        AUTOSTART_RST = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TGO, ST_TWAIT, ST_TMUL, ST_TFIN,
        ST_NSET, ST_MLO, ST_MHI, ST_ADJ, ST_SADD, ST_RGO, ST_RWAIT, ST_RCMP,
        ST_INC, ST_SGO, ST_SWAIT, ST_FGO, ST_FWAIT, ST_SUM, ST_SECS, ST_DONE
    } t_state;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_res;

endpackage

/* hdl/tfts_div.sv */
// ----------------------------------------------------------------------------
// tfts_div
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module tfts_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tfts_pkg::DIV_W-1:0]  i_dividend,
    input  logic [tfts_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_busy,
    output tfts_pkg::t_div_res          o_res
);
    localparam int unsigned CNT_W = $clog2(tfts_pkg::DIV_W + 1);

    logic [tfts_pkg::DIV_W-1:0] r_q;
    logic [tfts_pkg::DVS_W-1:0] r_rem;
    logic [tfts_pkg::DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [tfts_pkg::DVS_W:0]   w_sh;
    logic                       w_ge;

    assign w_sh = {r_rem, r_q[tfts_pkg::DIV_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(tfts_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[tfts_pkg::DIV_W-2:0], w_ge};
            r_rem <= w_ge ? tfts_pkg::DVS_W'(w_sh - {1'b0, r_dvs})
                          : w_sh[tfts_pkg::DVS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_res.done = r_done;
    assign o_res.quot = r_q;
    assign o_res.rem  = r_rem;
endmodule

/* hdl/tx_frame_time_scheduler_core.sv */
// ----------------------------------------------------------------------------
// tx_frame_time_scheduler_core
// Transmit burst time scheduler with one shared divider and multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_valid/o_ready) carries request words: timing update,
//  enable update or frame tick. Output channel (o_valid/i_ready) carries
//  one burst time word per frame tick; other requests give no word.
//  Config port: i_cfg_we writes i_cfg_data to register i_cfg_addr at once;
//  write only while the block is idle.
//  Work per request: an enable update is registered on acceptance; a timing
//  update runs one divide plus a multiply; a frame tick runs two divides,
//  three when the counter realignment runs. Words are worked one at a time
//  on the shared bit-serial divider; o_ready is high only while the
//  sequencer is idle.
//  Reset (synchronous, active low) loads register defaults, clears the
//  frame counter and reference state and sets the first-burst flag.
//  A stalled receiver holds the result in the output register; the block
//  still takes the next word and works it up to the point of output.
// ----------------------------------------------------------------------------
`include "tx_frame_time_scheduler_core_macros.svh"

module tx_frame_time_scheduler_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_req_type,
    input  logic [63:0]                  i_rx_frame_start,
    input  logic signed [31:0]           i_clock_drift,
    input  logic                         i_enable,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [63:0]                  o_tx_secs,
    output logic [31:0]                  o_tx_frac_q32,
    output logic                         o_null_frame,
    output logic [63:0]                  o_frame_number,
    input  logic                         i_cfg_we,
    input  logic [tfts_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [tfts_pkg::CFG_DW-1:0]  i_cfg_data
);

    // config registers
    logic [7:0]  r_pps;
    logic [31:0] r_fi;
    logic [31:0] r_sp;
    logic [32:0] r_off;
    logic [4:0]  r_start_s;

    // scheduler state
    logic [63:0] r_fc;
    logic [63:0] r_ref_start;
    logic [63:0] r_ref_count;
    logic [31:0] r_drift;
    logic [31:0] r_phase;
    logic        r_first;
    logic        r_tx_en;
    logic        r_realigned;

    // work registers
    tfts_pkg::t_state r_state, n_state;
    logic [63:0] r_rx;
    logic [31:0] r_drift_in;
    logic [63:0] r_n;
    logic [63:0] r_plo;
    logic [63:0] r_prod;
    logic [63:0] r_acc;     // adjust, then drifted start, then Q32 sum
    logic [63:0] r_secs;
    logic [7:0]  r_rem8;
    logic [31:0] r_frac;

    // output register
    logic        r_ovalid;
    logic [63:0] r_o_secs;
    logic [31:0] r_o_frac;
    logic        r_o_null;
    logic [63:0] r_o_fn;

    logic        w_acc_in;
    logic        w_load_out;
    logic [31:0] w_fi;
    logic [7:0]  w_pps;
    logic [31:0] w_mag;
    logic [31:0] w_ma, w_mb;
    logic        w_div_start;
    logic [63:0] w_dvd;
    logic [31:0] w_dvs;
    logic        w_div_busy;
    tfts_pkg::t_div_res w_div;
    logic [64:0] w_lo;
    logic [63:0] w_m;

    assign w_fi  = (r_fi == '0) ? 32'd1 : r_fi;
    assign w_pps = (r_pps == '0) ? 8'd1 : r_pps;
    // magnitude of the Q16.16 drift; the most negative value maps onto itself
    assign w_mag = r_drift[31] ? (~r_drift + 32'd1) : r_drift;

    assign o_ready    = (r_state == tfts_pkg::ST_IDLE);
    assign w_acc_in   = i_valid && o_ready;
    assign w_load_out = (r_state == tfts_pkg::ST_DONE) && (!r_ovalid || i_ready);

    // round half away from zero on the magnitude, then shift out the Q16 part
    assign w_lo = {1'b0, r_plo} + 65'h8000;
    assign w_m  = w_div.quot + r_n;

    tfts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_div_busy),
        .o_res      (w_div)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tfts_pkg::ST_IDLE: begin
                if (w_acc_in) begin
                    if (i_req_type == tfts_pkg::REQ_TIMING) begin
                        n_state = tfts_pkg::ST_TGO;
                    end else if (i_req_type == tfts_pkg::REQ_TICK) begin
                        n_state = (!r_realigned && r_ref_start != '0)
                                  ? tfts_pkg::ST_NSET : tfts_pkg::ST_INC;
                    end
                end
            end
            tfts_pkg::ST_TGO:   n_state = tfts_pkg::ST_TWAIT;
            tfts_pkg::ST_TWAIT: if (w_div.done) n_state = tfts_pkg::ST_TMUL;
            tfts_pkg::ST_TMUL:  n_state = tfts_pkg::ST_TFIN;
            tfts_pkg::ST_TFIN:  n_state = tfts_pkg::ST_IDLE;
            tfts_pkg::ST_NSET:  n_state = tfts_pkg::ST_MLO;
            tfts_pkg::ST_MLO:   n_state = tfts_pkg::ST_MHI;
            tfts_pkg::ST_MHI:   n_state = tfts_pkg::ST_ADJ;
            tfts_pkg::ST_ADJ:   n_state = tfts_pkg::ST_SADD;
            tfts_pkg::ST_SADD:  n_state = tfts_pkg::ST_RGO;
            tfts_pkg::ST_RGO:   n_state = tfts_pkg::ST_RWAIT;
            tfts_pkg::ST_RWAIT: if (w_div.done) n_state = tfts_pkg::ST_RCMP;
            tfts_pkg::ST_RCMP:  n_state = tfts_pkg::ST_INC;
            tfts_pkg::ST_INC:   n_state = tfts_pkg::ST_SGO;
            tfts_pkg::ST_SGO:   n_state = tfts_pkg::ST_SWAIT;
            tfts_pkg::ST_SWAIT: if (w_div.done) n_state = tfts_pkg::ST_FGO;
            tfts_pkg::ST_FGO:   n_state = tfts_pkg::ST_FWAIT;
            tfts_pkg::ST_FWAIT: if (w_div.done) n_state = tfts_pkg::ST_SUM;
            tfts_pkg::ST_SUM:   n_state = tfts_pkg::ST_SECS;
            tfts_pkg::ST_SECS:  n_state = tfts_pkg::ST_DONE;
            tfts_pkg::ST_DONE:  if (w_load_out) n_state = tfts_pkg::ST_IDLE;
            default:            n_state = tfts_pkg::ST_IDLE;
        endcase
    end

    // ---------------- unit control ----------------
    always_comb begin
        w_div_start = 1'b0;
        w_dvd       = r_rx;
        w_dvs       = w_fi;
        w_ma        = w_div.rem;
        w_mb        = r_sp;
        case (r_state)
            tfts_pkg::ST_TGO: begin
                w_div_start = 1'b1;
            end
            tfts_pkg::ST_RGO: begin
                w_div_start = 1'b1;
                w_dvd       = r_acc;
            end
            tfts_pkg::ST_SGO: begin
                w_div_start = 1'b1;
                w_dvd       = r_fc;
                w_dvs       = {24'd0, w_pps};
            end
            tfts_pkg::ST_FGO: begin
                // (fc mod pps) * 2^32 / pps, floor
                w_div_start = 1'b1;
                w_dvd       = {24'd0, r_rem8, 32'd0};
                w_dvs       = {24'd0, w_pps};
            end
            tfts_pkg::ST_MLO: begin
                w_ma = w_mag;
                w_mb = r_n[31:0];
            end
            tfts_pkg::ST_MHI: begin
                w_ma = w_mag;
                w_mb = r_n[63:32];
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    // shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_ma) * 64'(w_mb);
    end

    // ---------------- config and control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfts_pkg::ST_IDLE;
            r_pps       <= tfts_pkg::PPS_RST;
            r_fi        <= tfts_pkg::FRAME_INT_RST;
            r_sp        <= tfts_pkg::SAMPLE_P_RST;
            r_off       <= '0;
            r_start_s   <= '0;
            r_fc        <= '0;
            r_ref_start <= '0;
            r_ref_count <= '0;
            r_drift     <= '0;
            r_phase     <= '0;
            r_first     <= 1'b1;
            // enable follows the autostart default; writes to the autostart
            // register address are ignored
            r_tx_en     <= tfts_pkg::AUTOSTART_RST;
            r_realigned <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    tfts_pkg::REG_PPS:       r_pps     <= i_cfg_data[7:0];
                    tfts_pkg::REG_FRAME_INT: r_fi      <= i_cfg_data[31:0];
                    tfts_pkg::REG_SAMPLE_P:  r_sp      <= i_cfg_data[31:0];
                    tfts_pkg::REG_OFFSET:    r_off     <= i_cfg_data;
                    tfts_pkg::REG_START_S:   r_start_s <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            if (w_acc_in && i_req_type == tfts_pkg::REQ_ENABLE) begin
                r_tx_en <= i_enable;
                if (!i_enable) begin
                    r_realigned <= 1'b0;
                end
            end
            if (r_state == tfts_pkg::ST_TFIN) begin
                r_phase     <= (r_prod[63:32] != '0) ? 32'hFFFF_FFFF : r_prod[31:0];
                r_ref_start <= r_rx - 64'(w_div.rem);
                r_ref_count <= r_fc;
                r_drift     <= r_drift_in;
            end
            if (r_state == tfts_pkg::ST_RCMP && r_fc < w_m) begin
                r_fc        <= w_m;
                r_realigned <= 1'b1;
            end
            if (r_state == tfts_pkg::ST_INC) begin
                r_fc <= r_fc + 64'd1;
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
                r_first  <= 1'b0;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_rx       <= i_rx_frame_start;
            r_drift_in <= i_clock_drift;
        end
        case (r_state)
            tfts_pkg::ST_NSET: r_n   <= r_fc - r_ref_count;
            tfts_pkg::ST_MHI:  r_plo <= r_prod;
            tfts_pkg::ST_ADJ:  r_acc <= 64'(w_lo[64:16]) + {r_prod[47:0], 16'd0};
            tfts_pkg::ST_SADD: r_acc <= r_ref_start + (r_drift[31] ? (64'd0 - r_acc) : r_acc);
            tfts_pkg::ST_SWAIT: begin
                if (w_div.done) begin
                    r_secs <= w_div.quot;
                    r_rem8 <= w_div.rem[7:0];
                end
            end
            tfts_pkg::ST_FWAIT: if (w_div.done) r_frac <= w_div.quot[31:0];
            tfts_pkg::ST_SUM: begin
                r_acc <= 64'(r_frac) + 64'(r_phase) + {{31{r_off[32]}}, r_off};
            end
            tfts_pkg::ST_SECS: begin
                // negative sum borrows one second
                r_secs <= r_acc[63] ? (r_secs - 64'd1) : (r_secs + {32'd0, r_acc[63:32]});
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_o_secs <= r_secs;
            r_o_frac <= r_acc[31:0];
            r_o_null <= r_first || !r_tx_en || (r_secs <= 64'(r_start_s));
            r_o_fn   <= r_fc;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_tx_secs      = r_o_secs;
    assign o_tx_frac_q32  = r_o_frac;
    assign o_null_frame   = r_o_null;
    assign o_frame_number = r_o_fn;

    // ---------------- assertions ----------------
    `TFTS_ASSERT_NEXT(a_div_runs, w_div_start, w_div_busy, "divider did not start")
    `TFTS_ASSERT(a_out_src, $rose(o_valid) |-> $past(r_state == tfts_pkg::ST_DONE),
        "result loaded outside done state")
    `TFTS_ASSERT(a_realign_src, $rose(r_realigned) |-> $past(r_state == tfts_pkg::ST_RCMP),
        "realignment outside compare step")
    `TFTS_ASSERT(a_no_start_busy, w_div_start |-> !w_div_busy,
        "divider restarted while busy")

endmodule
